[design/bitonic_sorter_defines.svh]
// ----------------------------------------------------------------------------
// Bitonic sorter assertion macros
// Shared concurrent assertion wrappers clocked on clk_i; BS_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BITONIC_SORTER_DEFINES_SVH
`define BITONIC_SORTER_DEFINES_SVH

// Checked only while out of reset.
`define BS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[design/bs_pkg.sv]
// ----------------------------------------------------------------------------
// Bitonic sorter package
// Payload structs, controller command struct, state codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bs_pkg;

  localparam int DATA_W = 32;

  // Largest signed value; fills the slots below the loaded elements.
  localparam logic signed [DATA_W-1:0] PAD_VALUE = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     overflow;
  } out_t;

  typedef struct packed {
    logic shift;  // move every element down one slot, new value at the top
    logic pad;    // overwrite the unused low slots with PAD_VALUE
    logic sort;   // apply one compare-exchange stage of the network
  } cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_PAD  = 4'b0010,
    ST_SORT = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

`default_nettype wire

[design/bs_datapath.sv]
// ----------------------------------------------------------------------------
// Bitonic sorter datapath
// Element register file with shift, pad and one network stage per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bs_datapath import bs_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int L  = $clog2(CAPACITY),
  localparam int N  = 1 << L,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int PW = $clog2(L + 1),
  localparam int QW = (L > 1) ? $clog2(L) : 1
) (
  input  wire logic                     clk_i,
  input  wire cmd_t                     cmd_i,
  input  wire logic [CW-1:0]            cnt_i,
  input  wire logic [PW-1:0]            p_i,
  input  wire logic [QW-1:0]            q_i,
  input  wire logic signed [DATA_W-1:0] in_value_i,
  output logic signed [DATA_W-1:0]      head_o
);

  localparam int IW = L + 2;

  logic signed [DATA_W-1:0] elem_q [N];
  logic signed [DATA_W-1:0] elem_d [N];

  // Elements enter at the top, so after a set of cnt elements the loaded
  // values sit in slots N-cnt .. N-1 and the slots below them are padded.
  always_comb begin
    logic [L:0]               idx;
    logic [L-1:0]             pidx;
    logic [IW-1:0]            sum;
    logic signed [DATA_W-1:0] partner;
    logic signed [DATA_W-1:0] mn;
    logic signed [DATA_W-1:0] mx;
    logic                     up;
    logic                     take_min;

    idx      = '0;
    pidx     = '0;
    sum      = '0;
    partner  = '0;
    mn       = '0;
    mx       = '0;
    up       = 1'b0;
    take_min = 1'b0;

    for (int i = 0; i < N; i++) begin
      elem_d[i] = elem_q[i];
    end

    if (cmd_i.shift) begin
      for (int i = 0; i < N - 1; i++) begin
        elem_d[i] = elem_q[i + 1];
      end
      elem_d[N-1] = in_value_i;
    end else if (cmd_i.pad) begin
      for (int i = 0; i < N; i++) begin
        sum = IW'(i) + IW'(cnt_i);
        if (sum < IW'(N)) begin
          elem_d[i] = PAD_VALUE;
        end
      end
    end else if (cmd_i.sort) begin
      // Stage with block size 2**p and partner distance 2**q. Both partners
      // share bit p, which selects an ascending or descending block.
      for (int i = 0; i < N; i++) begin
        idx      = (L + 1)'(i);
        pidx     = idx[L-1:0] ^ (L'(1) << q_i);
        partner  = elem_q[pidx];
        mn       = (elem_q[i] < partner) ? elem_q[i] : partner;
        mx       = (elem_q[i] < partner) ? partner : elem_q[i];
        up       = ~idx[p_i];
        take_min = (idx[q_i] == 1'b0) == up;
        elem_d[i] = take_min ? mn : mx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign head_o = elem_q[0];

endmodule

`default_nettype wire

[design/bs_ctrl.sv]
// ----------------------------------------------------------------------------
// Bitonic sorter controller
// Load, pad, sort-stage sequencing and emission of the sorted set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitonic_sorter_defines.svh"

module bs_ctrl import bs_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int L  = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int PW = $clog2(L + 1),
  localparam int QW = (L > 1) ? $clog2(L) : 1
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_last_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output cmd_t         cmd_o,
  output logic [CW-1:0] cnt_o,
  output logic [PW-1:0] p_o,
  output logic [QW-1:0] q_o,
  output logic         final_o,
  output logic         overflow_o
);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          dropped_q, dropped_d;
  logic [PW-1:0] p_q, p_d;
  logic [QW-1:0] q_q, q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      dropped_q <= 1'b0;
      p_q       <= '0;
      q_q       <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      p_q       <= p_d;
      q_q       <= q_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    p_d         = p_q;
    q_d         = q_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CW'(CAPACITY)) begin
            cmd_o.shift = 1'b1;
            cnt_d       = cnt_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        p_d       = PW'(1);
        q_d       = '0;
        state_d   = ST_SORT;
      end
      ST_SORT: begin
        cmd_o.sort = 1'b1;
        // The distance counts down to zero, then the next block size starts
        // with a distance of half that block.
        if (q_q == '0) begin
          if (p_q == PW'(L)) begin
            state_d = ST_EMIT;
          end else begin
            p_d = p_q + PW'(1);
            q_d = QW'(p_q);
          end
        end else begin
          q_d = q_q - QW'(1);
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          cnt_d       = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign cnt_o      = cnt_q;
  assign p_o        = p_q;
  assign q_o        = q_q;
  assign final_o    = (cnt_q == CW'(1));
  assign overflow_o = dropped_q;

  `BS_ASSERT_ALWAYS(a_no_dual_side, !(in_ready_o && out_valid_o), "input and output open together")
  `BS_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "element count above capacity")
  `BS_ASSERT(a_emit_nonempty, (state_q == ST_EMIT) |-> (cnt_q != '0), "emitting an empty set")
  `BS_ASSERT(a_stage_range, (state_q == ST_SORT) |-> (p_q != '0 && p_q <= PW'(L) && PW'(q_q) < p_q), "sort stage out of range")
  `BS_ASSERT(a_close_clears, (out_valid_o && out_ready_i && final_o) |=> (cnt_q == '0 && !dropped_q && state_q == ST_LOAD), "set not cleared after last transfer")

endmodule

`default_nettype wire

[design/bitonic_sorter.sv]
// ----------------------------------------------------------------------------
// Bitonic sorter
// Collects a set of signed values, sorts it ascending and streams it out.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_data_i  (value, last)
// out       output     out_valid_o / out_ready_i out_data_o (sorted_value, final_res, overflow)
//
// Loading shifts each input value into the element registers, up to CAPACITY of
// them. After the transfer marked last, a pad step and L*(L+1)/2 network stages
// follow, L = log2 of the network size (10 stages for a capacity of 16), one stage
// per cycle of the datapath. Results then leave at one per cycle while out_ready_i
// is high; no input is taken until the last result of the set has been transferred.
// Reset clears the controller only; the element registers need no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bitonic_sorter import bs_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int L  = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(L + 1);
  localparam int QW = (L > 1) ? $clog2(L) : 1;

  cmd_t                     cmd;
  logic [CW-1:0]            cnt;
  logic [PW-1:0]            p;
  logic [QW-1:0]            q;
  logic                     final_res;
  logic                     overflow;
  logic signed [DATA_W-1:0] head;

  bs_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .cnt_o      (cnt),
    .p_o        (p),
    .q_o        (q),
    .final_o    (final_res),
    .overflow_o (overflow)
  );

  bs_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .cnt_i     (cnt),
    .p_i       (p),
    .q_i       (q),
    .in_value_i(in_data_i.value),
    .head_o    (head)
  );

  always_comb begin
    out_data_o.sorted_value = head;
    out_data_o.final_res    = final_res;
    out_data_o.overflow     = overflow;
  end

endmodule

`default_nettype wire
